@@ rtl/sign_magnitude_fixed_divider_top_macros.svh @@
// assertion macros for the sign-magnitude divider checker
// expects signals named clk and arst_n in the scope where a macro is used
`ifndef SIGN_MAGNITUDE_FIXED_DIVIDER_TOP_MACROS_SVH
`define SIGN_MAGNITUDE_FIXED_DIVIDER_TOP_MACROS_SVH

// same-cycle implication
`define SMFD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smfd assertion failed");

// next-cycle implication
`define SMFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smfd assertion failed");

`endif

@@ rtl/smfd_pkg.sv @@
// shared types and constants for the sign-magnitude fixed-point divider
// no dependencies
`default_nettype none

package smfd_pkg;

	localparam int MAG_BITS = 31;
	localparam int FRAC_BITS_DEF = 12;
	localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

	// data carried from cell to cell
	typedef struct packed {
		logic [MAG_BITS-1:0] rem;   // partial remainder, below dvs
		logic [MAG_BITS-1:0] dvs;   // divisor magnitude
		logic [MAG_BITS-1:0] low;   // dividend bits still to bring down, msb first
		logic [MAG_BITS-1:0] quo;   // quotient bits so far
		logic                sign;
		logic                ovf;
		logic                dz;
	} lane_t;

endpackage

`default_nettype wire

@@ rtl/smfd_entry.sv @@
// entry stage: splits the operands, checks overflow and divide by zero up front
// depends on smfd_pkg
`default_nettype none

module smfd_entry #(
	parameter int FRAC_BITS = smfd_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [31:0]        dividend,
	input  wire logic [31:0]        divisor,
	output logic                    out_valid,
	output smfd_pkg::lane_t         out_lane
);
	import smfd_pkg::*;

	localparam int NW = 2 * MAG_BITS;

	logic [MAG_BITS-1:0] amag;
	logic [MAG_BITS-1:0] bmag;
	logic [NW-1:0]       scaled;
	logic [MAG_BITS-1:0] hi_part;
	logic                a_zero;
	logic                b_zero;
	lane_t               lane_d;
	logic                valid_s1;
	lane_t               lane_s1;

	assign amag    = dividend[MAG_BITS-1:0];
	assign bmag    = divisor[MAG_BITS-1:0];
	assign scaled  = NW'(amag) << FRAC_BITS;
	assign hi_part = scaled[NW-1:MAG_BITS];
	assign a_zero  = (amag == '0);
	assign b_zero  = (bmag == '0);

	always_comb begin
		lane_d.sign = dividend[MAG_BITS] ^ divisor[MAG_BITS];
		lane_d.quo  = '0;
		if (a_zero) begin
			// all-ones divisor keeps every quotient bit at zero
			lane_d.rem = '0;
			lane_d.low = '0;
			lane_d.dvs = MAG_MAX;
			lane_d.ovf = 1'b0;
			lane_d.dz  = 1'b0;
		end else begin
			lane_d.rem = hi_part;
			lane_d.low = scaled[MAG_BITS-1:0];
			lane_d.dvs = bmag;
			// quotient exceeds 31 bits exactly when the high part reaches the divisor
			lane_d.ovf = (hi_part >= bmag);
			lane_d.dz  = b_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_lane  = lane_s1;

endmodule

`default_nettype wire

@@ rtl/smfd_cell.sv @@
// one restoring-division cell: brings down one dividend bit, yields one quotient bit
// depends on smfd_pkg
`default_nettype none

module smfd_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire smfd_pkg::lane_t    in_lane,
	output logic                    out_valid,
	output smfd_pkg::lane_t         out_lane
);
	import smfd_pkg::*;

	logic [MAG_BITS:0]   shifted;
	logic [MAG_BITS+1:0] diff;
	logic                ge;
	lane_t               lane_d;
	logic                valid_q;
	lane_t               lane_q;

	assign shifted = {in_lane.rem, in_lane.low[MAG_BITS-1]};
	assign diff    = {1'b0, shifted} - {2'b00, in_lane.dvs};
	assign ge      = !diff[MAG_BITS+1];

	always_comb begin
		lane_d     = in_lane;
		lane_d.rem = ge ? diff[MAG_BITS-1:0] : shifted[MAG_BITS-1:0];
		lane_d.low = {in_lane.low[MAG_BITS-2:0], 1'b0};
		lane_d.quo = {in_lane.quo[MAG_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= lane_d;
		end
	end

	assign out_valid = valid_q;
	assign out_lane  = lane_q;

endmodule

`default_nettype wire

@@ rtl/sign_magnitude_fixed_divider_top.sv @@
// channel  | handshake           | payload
// in       | in_valid, in_stall  | dividend[31:0], divisor[31:0]
// out      | out_valid, out_stall| quotient[31:0], overflow, divide_by_zero
//
// one item per cycle unless a held result stalls the chain; stages: entry stage, 31 division cells, output register
// each cell does one 32-bit subtract and compare, which sets the clock period
// arst_n clears every valid bit; payload registers are not reset
// a stalled result holds the whole chain, and in_stall rises in the same cycle
//
// top level: entry stage, chain of division cells, output register
// depends on smfd_pkg, smfd_entry, smfd_cell
`default_nettype none

module sign_magnitude_fixed_divider_top #(
	parameter int FRAC_BITS = smfd_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      quotient,
	output logic             overflow,
	output logic             divide_by_zero
);
	import smfd_pkg::*;

	logic               en;
	logic [MAG_BITS:0]  chain_valid;
	lane_t              chain_lane [MAG_BITS+1];
	lane_t              last_lane;
	logic               out_valid_q;
	logic [31:0]        quotient_q;
	logic               overflow_q;
	logic               dz_q;

	// whole chain moves unless a finished item is held at the output
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	smfd_entry #(
		.FRAC_BITS(FRAC_BITS)
	) u_entry (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.dividend (dividend),
		.divisor  (divisor),
		.out_valid(chain_valid[0]),
		.out_lane (chain_lane[0])
	);

	for (genvar i = 0; i < MAG_BITS; i++) begin : g_cell
		smfd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (chain_valid[i]),
			.in_lane  (chain_lane[i]),
			.out_valid(chain_valid[i+1]),
			.out_lane (chain_lane[i+1])
		);
	end

	assign last_lane = chain_lane[MAG_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain_valid[MAG_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_q <= {last_lane.sign, last_lane.ovf ? MAG_MAX : last_lane.quo};
			overflow_q <= last_lane.ovf;
			dz_q       <= last_lane.dz;
		end
	end

	assign out_valid      = out_valid_q;
	assign quotient       = quotient_q;
	assign overflow       = overflow_q;
	assign divide_by_zero = dz_q;

endmodule

`default_nettype wire

@@ rtl/smfd_checker.sv @@
// port-level checks for the sign-magnitude divider, bound to the top level
// depends on sign_magnitude_fixed_divider_top_macros.svh
`default_nettype none

`include "sign_magnitude_fixed_divider_top_macros.svh"

module smfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] quotient,
	input wire logic        overflow,
	input wire logic        divide_by_zero
);

	// a flagged zero divisor always saturates
	`SMFD_ASSERT_IMPL(a_dz_sets_ovf, out_valid && divide_by_zero, overflow)
	// saturated magnitude is all ones
	`SMFD_ASSERT_IMPL(a_ovf_mag_max, out_valid && overflow, quotient[30:0] == 31'h7fffffff)
	// input side stalls only when a result is held at the output
	`SMFD_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)
	// a held result stays put
	`SMFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(quotient))

endmodule

bind sign_magnitude_fixed_divider_top smfd_checker u_smfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.quotient      (quotient),
	.overflow      (overflow),
	.divide_by_zero(divide_by_zero)
);

`default_nettype wire

@@ tb/sv/sign_magnitude_fixed_divider_top_tb.sv @@
// self-checking testbench for the sign-magnitude fixed-point divider
// depends on smfd_pkg and sign_magnitude_fixed_divider_top; random input bursts and random output stalls
`default_nettype none

module sign_magnitude_fixed_divider_top_tb;

	import smfd_pkg::*;

	localparam int FRAC_BITS = FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [31:0] quotient;
		logic        overflow;
		logic        divide_by_zero;
	} div_result_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] dividend = '0;
	logic [31:0] divisor = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] quotient;
	logic        overflow;
	logic        divide_by_zero;

	div_result_t pending_quotients[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_phase_left = 0;
	int          stall_run = 0;

	sign_magnitude_fixed_divider_top #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.dividend(dividend),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quotient(quotient),
		.overflow(overflow),
		.divide_by_zero(divide_by_zero)
	);

	always #5 clk = ~clk;

	// exact quotient magnitude, saturated to 31 bits; sign is always the xor
	function automatic div_result_t sm_divide(logic [31:0] a, logic [31:0] b);
		logic [63:0] num;
		logic [63:0] q;
		div_result_t r;
		r.quotient = '0;
		r.quotient[31] = a[31] ^ b[31];
		r.overflow = 1'b0;
		r.divide_by_zero = 1'b0;
		if (a[30:0] == '0) begin
			r.quotient[30:0] = '0;
		end else if (b[30:0] == '0) begin
			r.quotient[30:0] = MAG_MAX;
			r.overflow = 1'b1;
			r.divide_by_zero = 1'b1;
		end else begin
			num = {33'd0, a[30:0]} << FRAC_BITS;
			q = num / {33'd0, b[30:0]};
			if (q > {33'd0, MAG_MAX}) begin
				r.quotient[30:0] = MAG_MAX;
				r.overflow = 1'b1;
			end else begin
				r.quotient[30:0] = q[30:0];
			end
		end
		return r;
	endfunction

	// magnitude of random bit length, zero included
	function automatic logic [30:0] rand_mag();
		int w;
		logic [31:0] v;
		w = $urandom_range(0, 31);
		v = $urandom;
		return v[30:0] & ((31'd1 << w) - 31'd1);
	endfunction

	// sender: bursts of random length, random gaps between them
	task automatic send_item(input logic [31:0] a, input logic [31:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		dividend <= a;
		divisor <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_quotients.push_back(sm_divide(a, b));
	endtask

	task automatic test_special_cases();
		send_item(32'h0000_0000, 32'h0000_0000);
		send_item(32'h8000_0000, 32'h0000_0000);
		send_item(32'h0000_0000, 32'h8000_0000);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h0000_1234, 32'h8000_0000);
		send_item(32'h0000_0001, 32'h0000_0000);
		send_item(32'h8000_0001, 32'h0000_0000);
		send_item(32'h7FFF_FFFF, 32'h8000_0000);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'h7FFF_FFFF, 32'h0000_0001);
		send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(32'h0000_0001, 32'h7FFF_FFFF);
		send_item(32'h8000_0001, 32'h7FFF_FFFF);
		send_item(32'h0000_1000, 32'h0000_1000);
		send_item(32'h8008_0000, 32'h8000_1000);
		// saturation edge: exactly the largest magnitude, then past it, then just under and one past it
		send_item(32'h7FFF_FFFF, 32'h0000_1000);
		send_item(32'h7FFF_FFFF, 32'h0000_0FFF);
		send_item(32'h0007_FFFF, 32'h0000_0001);
		send_item(32'h0008_0000, 32'h0000_0001);
		send_item(32'h8007_FFFF, 32'h8000_0001);
		send_item(32'h5555_5555, 32'hAAAA_AAAA);
		send_item(32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	task automatic test_saturation_edge(input int count);
		logic [63:0] t;
		logic [31:0] a;
		logic [31:0] b;
		int delta;
		repeat (count) begin
			b = $urandom;
			b[30:0] = 31'($urandom_range(1, 8191));
			t = ({33'd0, MAG_MAX} * {33'd0, b[30:0]}) >> FRAC_BITS;
			delta = int'($urandom_range(0, 6)) - 3;
			t = t + 64'(signed'(delta));
			if (t == '0 || t[63]) t = 64'd1;
			if (t > {33'd0, MAG_MAX}) t = {33'd0, MAG_MAX};
			a = $urandom;
			a[30:0] = t[30:0];
			send_item(a, b);
		end
	endtask

	task automatic test_random_words(input int count);
		logic [31:0] a;
		logic [31:0] b;
		repeat (count) begin
			a = $urandom;
			b = $urandom;
			if ($urandom_range(0, 31) == 0) a[30:0] = '0;
			if ($urandom_range(0, 31) == 0) b[30:0] = '0;
			send_item(a, b);
		end
	endtask

	task automatic test_mixed_magnitudes(input int count);
		logic [31:0] a;
		logic [31:0] b;
		repeat (count) begin
			a = $urandom;
			b = $urandom;
			a[30:0] = rand_mag();
			b[30:0] = rand_mag();
			send_item(a, b);
		end
	endtask

	// receiver stall pattern changes character from phase to phase, each phase of random length
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_phase_left <= $urandom_range(50, 300);
		end else begin
			stall_phase_left <= stall_phase_left - 1;
		end
		case (stall_mode)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_HEAVY: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_run == 0) begin
					out_stall <= ~out_stall;
					stall_run <= $urandom_range(1, 40);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		div_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_quotients.size() == 0) begin
				$error("unexpected item: quotient %h overflow %b divide_by_zero %b",
					quotient, overflow, divide_by_zero);
				mismatches++;
			end else begin
				want = pending_quotients.pop_front();
				if (quotient !== want.quotient) begin
					$error("quotient: expected %h, got %h", want.quotient, quotient);
					mismatches++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %b, got %b", want.overflow, overflow);
					mismatches++;
				end
				if (divide_by_zero !== want.divide_by_zero) begin
					$error("divide_by_zero: expected %b, got %b",
						want.divide_by_zero, divide_by_zero);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_saturation_edge(300);
		test_random_words(500);
		test_mixed_magnitudes(500);
		in_valid <= 1'b0;
		while (pending_quotients.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/smfd_pkg.sv
rtl/smfd_entry.sv
rtl/smfd_cell.sv
rtl/sign_magnitude_fixed_divider_top.sv
rtl/smfd_checker.sv
tb/sv/sign_magnitude_fixed_divider_top_tb.sv
